[rtl/rss_pkg.sv]
// Shared types, constants and helpers for the sorted reservoir sampler.
`default_nettype none
package rss_pkg;
	localparam int RES_DEPTH = 32;
	localparam int IDX_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int CNT_W = $clog2(RES_DEPTH + 1);
	localparam int VAL_W = 31;
	localparam int SEEN_W = 32;
	localparam int CFG_W = 6;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);
	localparam int DIV_STEPS = VAL_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [SEEN_W-1:0] seen_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SORT
	} top_state_t;

	typedef enum logic [1:0] {
		SS_IDLE,
		SS_SCAN,
		SS_EMIT
	} sort_state_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		val_t data;
	} wr_req_t;

	typedef struct packed {
		logic go;
		cnt_t n;
	} sort_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic cnt_t min_cnt(input cnt_t a, input cnt_t b);
		return (a < b) ? a : b;
	endfunction
endpackage
`default_nettype wire

[rtl/rss_in_if.sv]
// Input channel: one stream element per transaction.
`default_nettype none
interface rss_in_if;
	import rss_pkg::*;
	logic valid;
	logic ready;
	val_t value;
	val_t random_word;
	logic last;
	modport source(output valid, output value, output random_word, output last, input ready);
	modport sink(input valid, input value, input random_word, input last, output ready);
endinterface
`default_nettype wire

[rtl/rss_out_if.sv]
// Output channel: one sampled value per transaction.
`default_nettype none
interface rss_out_if;
	import rss_pkg::*;
	logic valid;
	logic ready;
	val_t sample_value;
	logic final_res;
	modport source(output valid, output sample_value, output final_res, input ready);
	modport sink(input valid, input sample_value, input final_res, output ready);
endinterface
`default_nettype wire

[rtl/rss_mod_unit.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module rss_mod_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire rss_pkg::val_t       dividend,
	input  wire rss_pkg::seen_t      divisor,
	output rss_pkg::div_stat_t       stat,
	output rss_pkg::seen_t           rem
);
	import rss_pkg::*;

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	val_t dvd_q;
	seen_t dvs_q;
	seen_t rem_q;
	logic [SEEN_W:0] trial;
	seen_t rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[VAL_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = SEEN_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = trial[SEEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand shift registers carry no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VAL_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

[rtl/rss_sorter.sv]
// Reservoir memory with a selection-sort emitter that streams the sample in ascending order.
`default_nettype none
module rss_sorter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rss_pkg::wr_req_t    wr,
	input  wire rss_pkg::sort_cmd_t  cmd,
	output logic                     busy,
	rss_out_if.source                samples
);
	import rss_pkg::*;

	val_t mem [RES_DEPTH];

	sort_state_t state_q, state_d;
	cnt_t n_q;
	cnt_t rd_idx_q;
	cnt_t emitted_q;
	logic [RES_DEPTH-1:0] taken_q;
	logic rd_vld_s1;
	idx_t rd_addr_s1;
	val_t rd_data_s1;
	val_t min_q;
	idx_t min_idx_q;
	logic min_found_q;
	logic out_valid_q;
	val_t out_value_q;
	logic out_final_q;

	logic scan_issue;
	logic better;
	logic emit;
	logic last_emit;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		rd_addr_s1 <= rd_idx_q[IDX_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		scan_issue = (state_q == SS_SCAN) && (rd_idx_q < n_q);
		better = rd_vld_s1 && !taken_q[rd_addr_s1] && (!min_found_q || rd_data_s1 < min_q);
		emit = (state_q == SS_EMIT) && (!out_valid_q || samples.ready);
		last_emit = (CNT_W'(emitted_q + 1'b1) == n_q);
		unique case (state_q)
			SS_IDLE: begin
				if (cmd.go) begin
					state_d = SS_SCAN;
				end
			end
			SS_SCAN: begin
				if (!scan_issue && !rd_vld_s1) begin
					state_d = SS_EMIT;
				end
			end
			SS_EMIT: begin
				if (emit) begin
					state_d = last_emit ? SS_IDLE : SS_SCAN;
				end
			end
			default: state_d = SS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
			n_q <= '0;
			rd_idx_q <= '0;
			emitted_q <= '0;
			taken_q <= '0;
			rd_vld_s1 <= 1'b0;
			min_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= scan_issue;
			if (scan_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (better) begin
				min_found_q <= 1'b1;
			end
			if (samples.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == SS_IDLE && cmd.go) begin
				n_q <= cmd.n;
				rd_idx_q <= '0;
				emitted_q <= '0;
				taken_q <= '0;
				min_found_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				taken_q[min_idx_q] <= 1'b1;
				emitted_q <= emitted_q + 1'b1;
				rd_idx_q <= '0;
				min_found_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			min_q <= rd_data_s1;
			min_idx_q <= rd_addr_s1;
		end
		if (emit) begin
			out_value_q <= min_q;
			out_final_q <= last_emit;
		end
	end

	assign busy = (state_q != SS_IDLE);
	assign samples.valid = out_valid_q;
	assign samples.sample_value = out_value_q;
	assign samples.final_res = out_final_q;

	a_emitted_le_n: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= n_q)
		else $error("more samples emitted than kept");

	a_taken_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(taken_q) == int'(emitted_q))
		else $error("taken mask out of step with emitted count");

	a_emit_has_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SS_EMIT) |-> min_found_q)
		else $error("emit state reached without a minimum");
endmodule
`default_nettype wire

[rtl/reservoir_sample_sorted.sv]
// Top level: reservoir sampling over a stream with sorted emission at the end of each set.
// A filling element is written straight into the reservoir; a replacing element goes through
// start, the 31 remainder steps in the bit-serial mod unit, and write-back.
// After an element flagged last, n kept values are emitted in ascending order; each result
// costs one scan of the reservoir memory.
// Reset clears the fill and seen counts and sets sample_size to 8; reservoir contents stay
// undefined until written, and no clearing pass is needed.
`default_nettype none
module reservoir_sample_sorted (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [rss_pkg::CFG_W-1:0] cfg_wdata,
	rss_in_if.sink                       items,
	rss_out_if.source                    samples
);
	import rss_pkg::*;

	top_state_t state_q, state_d;
	logic [CFG_W-1:0] sample_size_q;
	cnt_t fill_q, fill_d;
	seen_t seen_q, seen_d;
	val_t value_q;
	logic last_q;

	cnt_t k;
	cnt_t fill_inc;
	cnt_t n;
	seen_t seen_inc;
	logic accept;
	logic div_start;
	div_stat_t div_stat;
	seen_t div_rem;
	wr_req_t wr;
	sort_cmd_t sort_cmd;
	logic sort_busy;

	always_comb begin
		if (int'(sample_size_q) < RES_DEPTH) begin
			k = CNT_W'(sample_size_q);
		end else begin
			k = CNT_W'(RES_DEPTH);
		end
	end

	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		seen_d = seen_q;
		items.ready = 1'b0;
		div_start = 1'b0;
		wr = '0;
		sort_cmd = '0;
		accept = 1'b0;
		fill_inc = CNT_W'(fill_q + 1'b1);
		seen_inc = (seen_q == '1) ? seen_q : seen_q + 1'b1;
		n = '0;
		unique case (state_q)
			ST_IDLE: begin
				items.ready = 1'b1;
				accept = items.valid;
				if (accept) begin
					seen_d = seen_inc;
					if (fill_q < k) begin
						wr.en = 1'b1;
						wr.addr = fill_q[IDX_W-1:0];
						wr.data = items.value;
						fill_d = fill_inc;
						if (items.last) begin
							n = min_cnt(fill_inc, k);
							sort_cmd.go = (n != '0);
							sort_cmd.n = n;
							fill_d = '0;
							seen_d = '0;
							state_d = (n != '0) ? ST_SORT : ST_IDLE;
						end
					end else begin
						div_start = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					// The remainder picks the slot; only slots below k are replaced.
					if (div_rem < SEEN_W'(k)) begin
						wr.en = 1'b1;
						wr.addr = div_rem[IDX_W-1:0];
						wr.data = value_q;
					end
					state_d = ST_IDLE;
					if (last_q) begin
						n = min_cnt(fill_q, k);
						sort_cmd.go = (n != '0);
						sort_cmd.n = n;
						fill_d = '0;
						seen_d = '0;
						state_d = (n != '0) ? ST_SORT : ST_IDLE;
					end
				end
			end
			ST_SORT: begin
				if (!sort_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sample_size_q <= CFG_RESET;
			fill_q <= '0;
			seen_q <= '0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			seen_q <= seen_d;
			if (cfg_we) begin
				sample_size_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= items.value;
			last_q <= items.last;
		end
	end

	rss_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (items.random_word),
		.divisor  (seen_inc),
		.stat     (div_stat),
		.rem      (div_rem)
	);

	rss_sorter u_sort (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.cmd     (sort_cmd),
		.busy    (sort_busy),
		.samples (samples)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= RES_DEPTH)
		else $error("fill count beyond reservoir depth");

	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle remainder unit");

	a_sort_free: assert property (@(posedge clk) disable iff (!arst_n)
		sort_cmd.go |-> !sort_busy)
		else $error("sort started while the sorter is busy");
endmodule
`default_nettype wire
